// ===== sv/cqi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqi_pkg: shared types for the indexed circular queue
// Request and response payloads, operation codes and status codes.
// ----------------------------------------------------------------------------
package cqi_pkg;

   localparam int DATA_W  = 32;
   localparam int POS_W   = 7;
   localparam int COUNT_W = 8;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_READ  = 2'd2,
      OP_WRITE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_BAD_POS = 2'd3
   } status_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  value;
      logic        [POS_W-1:0]   position;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  read_data;
      status_type                status;
      logic        [COUNT_W-1:0] count;
      logic                      is_empty;
      logic                      is_full;
   } rsp_type;

endpackage

// ===== sv/cqi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqi_ram: element storage of the indexed circular queue
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cqi_ram #(
   parameter int DEPTH = 128
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [cqi_pkg::DATA_W-1:0]    wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [cqi_pkg::DATA_W-1:0]    rd_data
);
   import cqi_pkg::*;

   logic [DATA_W-1:0] storage_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= storage_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/circular_queue_indexed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_indexed: ring-buffer queue with indexed access
// FIFO of signed 32-bit words with push, pop, read and write at an offset.
// ----------------------------------------------------------------------------
// Usage:
//   A request (op, value, position on req_payload) transfers at a rising edge
//   with start high and busy low. busy stays low, so a request may be issued
//   in every cycle: one item per cycle, the rate of the storage memory's
//   single write port and single read port.
//   Each request gives exactly one response on rsp_payload, marked by
//   rsp_valid for one cycle, in the cycle right after the request transfer.
//   Pointers and count are updated at the transfer edge; a read is issued to
//   the memory at that edge too, so a following write to the same slot does
//   not disturb data already on its way out.
//   Rejected requests (push when full, pop when empty, position at or beyond
//   the count) change nothing and return read_data 0 with their status code.
//   count reports the low 8 bits of the element count after the operation.
//   Synchronous reset empties the queue; storage contents are not cleared
//   and are only ever read at slots written earlier.
//   The receiver cannot stall: a response must be taken in its cycle.
// ----------------------------------------------------------------------------
module circular_queue_indexed #(
   parameter int DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cqi_pkg::req_type  req_payload,
   output logic              rsp_valid,
   output cqi_pkg::rsp_type  rsp_payload
);
   import cqi_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = IW + 1;
   localparam int MW = ((IW > POS_W) ? IW : POS_W) + 1;

   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;

   logic          rsp_valid_ff;
   logic          rd_sel_ff, rd_sel_in;
   status_type    status_ff, status_in;
   logic [COUNT_W-1:0] count_out_ff;
   logic          empty_ff, full_ff;

   logic          accept;
   logic [MW-1:0] pos_ext, count_ext, slot_sum;
   logic [IW-1:0] slot;
   logic          pos_ok;
   logic          is_full_now, is_empty_now;

   logic                wr_en, rd_en;
   logic [IW-1:0]       wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic [DATA_W-1:0]   rd_data;
   logic [CW+COUNT_W-1:0] count_wide;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign pos_ext      = MW'(req_payload.position);
   assign count_ext    = MW'(count_ff);
   assign slot_sum     = MW'(head_ff) + pos_ext;
   assign slot         = slot_sum[IW-1:0];
   assign pos_ok       = pos_ext < count_ext;
   assign is_full_now  = count_ff == CW'(DEPTH);
   assign is_empty_now = count_ff == '0;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = STATUS_OK;
      rd_sel_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      wr_data   = req_payload.value;
      rd_en     = 1'b0;
      if (accept) begin
         unique case (req_payload.op)
            OP_PUSH: begin
               if (is_full_now) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  tail_in  = tail_ff + IW'(1);
                  count_in = count_ff + CW'(1);
               end
            end
            OP_POP: begin
               if (is_empty_now) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  head_in  = head_ff + IW'(1);
                  count_in = count_ff - CW'(1);
               end
            end
            OP_READ: begin
               if (!pos_ok) begin
                  status_in = STATUS_BAD_POS;
               end else begin
                  rd_en     = 1'b1;
                  rd_sel_in = 1'b1;
               end
            end
            OP_WRITE: begin
               if (!pos_ok) begin
                  status_in = STATUS_BAD_POS;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = slot;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   assign count_wide = {{COUNT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_sel_ff    <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
         rd_sel_ff    <= rd_sel_in;
      end
   end

   // response fields, captured with the transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         count_out_ff <= count_wide[COUNT_W-1:0];
         empty_ff     <= count_in == '0;
         full_ff      <= count_in == CW'(DEPTH);
      end
   end

   cqi_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_payload.read_data = rd_sel_ff ? rd_data : '0;
   assign rsp_payload.status    = status_ff;
   assign rsp_payload.count     = count_out_ff;
   assign rsp_payload.is_empty  = empty_ff;
   assign rsp_payload.is_full   = full_ff;

   // every transfer gives exactly one response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("response missing after request transfer");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("response without request transfer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count beyond capacity");

   // pointer distance agrees with the count
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (tail_ff - head_ff) == count_ff[IW-1:0])
      else $error("pointers disagree with count");

   a_reject_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != STATUS_OK) |-> rsp_payload.read_data == '0)
      else $error("rejected request returned data");

endmodule
